@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker of the framer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, off while reset is low.
`define SFCF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that is also checked while reset is low.
`define SFCF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sfcf_pkg.sv @@
// Types, constants and defaults shared by the SPI frame CRC framer files.
package sfcf_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_crc;
    typedef logic [6:0]  t_index;
    typedef logic [1:0]  t_status;

    // Frame geometry defaults.
    localparam int HEADER_BYTES_DEF = 7;
    localparam int DATA_BYTES_DEF   = 100;

    // CRC-16/MODBUS, reflected form.
    localparam t_crc CRC_POLY = 16'hA001;
    localparam t_crc CRC_INIT = 16'hFFFF;

    // Received header byte that carries the partner's model code.
    localparam int    MODEL_INDEX = 2;
    localparam t_byte MODEL_RESET = 8'd76;

    // Frame status codes, reported on the last byte.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_HDR_CRC  = 2'd1;
    localparam t_status ST_MODEL    = 2'd2;
    localparam t_status ST_DATA_CRC = 2'd3;

endpackage

@@ rtl/sfcf_in_if.sv @@
// Input channel of the framer: one transmit byte and one received byte per transfer.
interface sfcf_in_if;
    import sfcf_pkg::*;

    logic  valid;
    logic  ready;
    logic  frame_start;
    t_byte tx_byte;
    t_byte rx_byte;

    modport source (output valid, output frame_start, output tx_byte, output rx_byte,
                    input ready);
    modport sink   (input valid, input frame_start, input tx_byte, input rx_byte,
                    output ready);
endinterface

@@ rtl/sfcf_out_if.sv @@
// Output channel of the framer: the framed bytes, their position and the frame status.
interface sfcf_out_if;
    import sfcf_pkg::*;

    logic    valid;
    logic    ready;
    t_byte   tx_out;
    t_byte   rx_out;
    t_index  byte_index;
    logic    last;
    t_status status;

    modport source (output valid, output tx_out, output rx_out, output byte_index,
                    output last, output status, input ready);
    modport sink   (input valid, input tx_out, input rx_out, input byte_index,
                    input last, input status, output ready);
endinterface

@@ rtl/spi_frame_crc_framer_unit.sv @@
// Top level of the SPI frame CRC framer: input register, frame logic, result register.
//
// The block frames one full-duplex SPI exchange of HEADER_BYTES + DATA_BYTES + 4
// bytes (111 by default). Each input transfer carries the byte to send and the byte
// received in the same slot; each output transfer returns one result. The transmit
// byte passes through except at the two CRC slots (after the header and after the
// data), where the block sends the CRC-16/MODBUS of that section, low byte first.
// The received byte always passes through. The block checks the received header
// CRC, the model byte at header index 2 against the expected_model register, and
// the received data CRC; on the last byte the status field reports the first of
// these that failed, and it is zero on every other byte.
// Setting frame_start on an input transfer abandons the current frame; after the
// last byte the next frame starts on its own.
// An input transfer is captured in the input register, and its result then moves to the result register.
// One item is accepted every cycle while the receiver keeps up: the CRC update for a
// byte is a single unrolled step between the input register and the result register.
// When the receiver stalls, the result register holds and the input register keeps
// filling; input ready drops only when both registers are full.
// Reset clears both valid bits, the frame position and the error flags, sets the CRCs
// to CRC_INIT and sets expected_model to 76. The register is written through i_cfg_we.
module spi_frame_crc_framer_unit #(
    parameter int HEADER_BYTES = sfcf_pkg::HEADER_BYTES_DEF,
    parameter int DATA_BYTES   = sfcf_pkg::DATA_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sfcf_in_if.sink           i_in,
    sfcf_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  sfcf_pkg::t_byte   i_cfg_data
);
    import sfcf_pkg::*;

    // Frame layout, all positions counted from zero.
    localparam int FRAME_LEN = HEADER_BYTES + DATA_BYTES + 4;
    localparam int POS_W     = $clog2(FRAME_LEN);

    localparam logic [POS_W-1:0] P_MODEL   = POS_W'(MODEL_INDEX);
    localparam logic [POS_W-1:0] P_HCRC_LO = POS_W'(HEADER_BYTES);
    localparam logic [POS_W-1:0] P_HCRC_HI = POS_W'(HEADER_BYTES + 1);
    localparam logic [POS_W-1:0] P_DCRC_LO = POS_W'(HEADER_BYTES + 2 + DATA_BYTES);

    // Input register.
    logic  r_s1_valid;
    logic  r_s1_start;
    t_byte r_s1_tx;
    t_byte r_s1_rx;

    // Frame state.
    logic [POS_W-1:0] r_pos,      n_pos;
    t_crc             r_tx_crc,   n_tx_crc;
    t_crc             r_rx_crc,   n_rx_crc;
    t_byte            r_rx_low,   n_rx_low;
    logic             r_hdr_bad,  n_hdr_bad;
    logic             r_mdl_bad,  n_mdl_bad;
    t_byte            r_exp_model;

    // Result register.
    logic    r_o_valid;
    t_byte   r_tx_out,  n_tx_out;
    t_byte   r_rx_out;
    t_index  r_idx;
    logic    r_last,    n_last;
    t_status r_status,  n_status;

    // Frame state as seen by the byte in the input register.
    logic [POS_W-1:0] w_pos;
    t_crc             w_tx_crc;
    t_crc             w_rx_crc;
    t_byte            w_rx_low;
    logic             w_hdr_bad;
    logic             w_mdl_bad;
    t_crc             w_tx_upd;
    t_crc             w_rx_upd;
    logic             w_crc_miss;

    logic w_out_ready;
    logic w_s1_move;
    logic w_in_take;

    assign w_out_ready = !r_o_valid || o_out.ready;
    assign w_s1_move   = r_s1_valid && w_out_ready;
    assign i_in.ready  = !r_s1_valid || w_out_ready;
    assign w_in_take   = i_in.valid && i_in.ready;

    // A frame start makes this byte see a freshly cleared frame.
    assign w_pos     = r_s1_start ? '0       : r_pos;
    assign w_tx_crc  = r_s1_start ? CRC_INIT : r_tx_crc;
    assign w_rx_crc  = r_s1_start ? CRC_INIT : r_rx_crc;
    assign w_rx_low  = r_s1_start ? 8'h00    : r_rx_low;
    assign w_hdr_bad = r_s1_start ? 1'b0     : r_hdr_bad;
    assign w_mdl_bad = r_s1_start ? 1'b0     : r_mdl_bad;

    sfcf_crc_byte u_tx_crc (
        .i_crc  (w_tx_crc),
        .i_byte (r_s1_tx),
        .o_crc  (w_tx_upd)
    );

    sfcf_crc_byte u_rx_crc (
        .i_crc  (w_rx_crc),
        .i_byte (r_s1_rx),
        .o_crc  (w_rx_upd)
    );

    // The received CRC word is the stored low byte with this byte on top.
    assign w_crc_miss = ({r_s1_rx, w_rx_low} != w_rx_crc);

    always_comb begin
        n_pos     = w_pos + POS_W'(1);
        n_tx_crc  = w_tx_crc;
        n_rx_crc  = w_rx_crc;
        n_rx_low  = w_rx_low;
        n_hdr_bad = w_hdr_bad;
        n_mdl_bad = w_mdl_bad;
        n_tx_out  = r_s1_tx;
        n_last    = 1'b0;
        n_status  = ST_OK;

        if (w_pos < P_HCRC_LO) begin
            // Header byte: both CRCs take it, and the model byte is checked.
            n_tx_crc = w_tx_upd;
            n_rx_crc = w_rx_upd;
            if (w_pos == P_MODEL && r_s1_rx != r_exp_model) begin
                n_mdl_bad = 1'b1;
            end
        end else if (w_pos == P_HCRC_LO || w_pos == P_DCRC_LO) begin
            // Low CRC byte: send ours, keep the partner's for the compare.
            n_tx_out = w_tx_crc[7:0];
            n_rx_low = r_s1_rx;
        end else if (w_pos == P_HCRC_HI) begin
            // High header CRC byte: compare, then restart both CRCs for the data.
            n_tx_out = w_tx_crc[15:8];
            if (w_crc_miss) begin
                n_hdr_bad = 1'b1;
            end
            n_tx_crc = CRC_INIT;
            n_rx_crc = CRC_INIT;
        end else if (w_pos < P_DCRC_LO) begin
            n_tx_crc = w_tx_upd;
            n_rx_crc = w_rx_upd;
        end else begin
            // Final byte: report the first failure and clear the frame.
            n_tx_out = w_tx_crc[15:8];
            n_last   = 1'b1;
            if (w_hdr_bad) begin
                n_status = ST_HDR_CRC;
            end else if (w_mdl_bad) begin
                n_status = ST_MODEL;
            end else if (w_crc_miss) begin
                n_status = ST_DATA_CRC;
            end
            n_pos     = '0;
            n_tx_crc  = CRC_INIT;
            n_rx_crc  = CRC_INIT;
            n_rx_low  = 8'h00;
            n_hdr_bad = 1'b0;
            n_mdl_bad = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_pos       <= '0;
            r_tx_crc    <= CRC_INIT;
            r_rx_crc    <= CRC_INIT;
            r_rx_low    <= 8'h00;
            r_hdr_bad   <= 1'b0;
            r_mdl_bad   <= 1'b0;
            r_exp_model <= MODEL_RESET;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_out_ready) begin
                r_o_valid <= r_s1_valid;
            end
            if (w_s1_move) begin
                r_pos     <= n_pos;
                r_tx_crc  <= n_tx_crc;
                r_rx_crc  <= n_rx_crc;
                r_rx_low  <= n_rx_low;
                r_hdr_bad <= n_hdr_bad;
                r_mdl_bad <= n_mdl_bad;
            end
            if (i_cfg_we) begin
                r_exp_model <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_start <= i_in.frame_start;
            r_s1_tx    <= i_in.tx_byte;
            r_s1_rx    <= i_in.rx_byte;
        end
        if (w_s1_move) begin
            r_tx_out <= n_tx_out;
            r_rx_out <= r_s1_rx;
            r_idx    <= t_index'(w_pos);
            r_last   <= n_last;
            r_status <= n_status;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.tx_out     = r_tx_out;
    assign o_out.rx_out     = r_rx_out;
    assign o_out.byte_index = r_idx;
    assign o_out.last       = r_last;
    assign o_out.status     = r_status;

endmodule

@@ rtl/sfcf_crc_byte.sv @@
// One-byte CRC-16/MODBUS update, eight reflected shift steps unrolled.
module sfcf_crc_byte (
    input  sfcf_pkg::t_crc  i_crc,
    input  sfcf_pkg::t_byte i_byte,
    output sfcf_pkg::t_crc  o_crc
);
    import sfcf_pkg::*;

    always_comb begin
        t_crc w_crc;
        w_crc = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (w_crc[0]) begin
                w_crc = (w_crc >> 1) ^ CRC_POLY;
            end else begin
                w_crc = w_crc >> 1;
            end
        end
        o_crc = w_crc;
    end

endmodule

@@ rtl/sfcf_checker.sv @@
// Port-level checker for the SPI frame CRC framer, bound to its top level.
`include "assert_macros.svh"

module sfcf_checker #(
    parameter int HEADER_BYTES = sfcf_pkg::HEADER_BYTES_DEF,
    parameter int DATA_BYTES   = sfcf_pkg::DATA_BYTES_DEF
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input sfcf_pkg::t_byte   i_tx_out,
    input sfcf_pkg::t_index  i_byte_index,
    input logic              i_last,
    input sfcf_pkg::t_status i_status
);
    import sfcf_pkg::*;

    localparam t_index LAST_INDEX = t_index'(HEADER_BYTES + DATA_BYTES + 3);

    // A failure code is only ever reported on the last byte.
    `SFCF_ASSERT(a_status_on_last, i_clk, i_rst_n,
        i_out_valid && i_status != ST_OK |-> i_last,
        "status set on a byte that is not the last")

    // The last byte always sits at the final frame position.
    `SFCF_ASSERT(a_last_index, i_clk, i_rst_n,
        i_out_valid && i_last |-> i_byte_index == LAST_INDEX,
        "last flag at the wrong position")

    // With the result register empty there is always room for another input.
    `SFCF_ASSERT(a_ready_when_empty, i_clk, i_rst_n,
        !i_out_valid |-> i_in_ready,
        "input stalled while the output is empty")

    // A stalled result keeps its byte.
    `SFCF_ASSERT(a_stall_holds, i_clk, i_rst_n,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tx_out),
        "stalled result changed")

    // Reset empties the pipeline.
    `SFCF_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !i_out_valid,
        "output valid after reset")

endmodule

bind spi_frame_crc_framer_unit sfcf_checker #(
    .HEADER_BYTES (HEADER_BYTES),
    .DATA_BYTES   (DATA_BYTES)
) u_sfcf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_tx_out     (o_out.tx_out),
    .i_byte_index (o_out.byte_index),
    .i_last       (o_out.last),
    .i_status     (o_out.status)
);
